// ===== rtl/red_pkg.sv =====
// Package for the rotary encoder event decoder: register map, phase and event codes.
// Shared by the interfaces, the register block, the decoder core and the top level.
package red_pkg;

  localparam int unsigned LimitW   = 24;
  localparam int unsigned ElapsedW = 25;
  localparam int unsigned AddrW    = 4;
  localparam int unsigned DataW    = 32;
  localparam int unsigned EventW   = 2;

  localparam logic [ElapsedW-1:0] ElapsedMax   = {ElapsedW{1'b1}};
  localparam logic [LimitW-1:0]   LimitDefault = LimitW'(1000);

  // Register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_BUTTON_PRESENT = 2'd0,
    REG_TIMEOUT_ENABLE = 2'd1,
    REG_TIMEOUT_LIMIT  = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    PH_WAIT_HIGH = 3'd0,
    PH_REST      = 3'd1,
    PH_BUTTON    = 3'd2,
    PH_LEFT      = 3'd3,
    PH_RIGHT     = 3'd4
  } phase_e;

  typedef enum logic [EventW-1:0] {
    EV_LEFT    = 2'd0,
    EV_RIGHT   = 2'd1,
    EV_BUTTON  = 2'd2,
    EV_TIMEOUT = 2'd3
  } event_e;

  // Configuration handed from the register block to the core
  typedef struct packed {
    logic              button_present;
    logic              timeout_enable;
    logic [LimitW-1:0] timeout_limit;
  } cfg_t;

endpackage

// ===== rtl/red_if.sv =====
// Stream interfaces of the decoder: pin sample words in, event words out.
// Depends on red_pkg for the event width.
interface red_in_if;
  logic valid;
  logic ready;
  logic a_level;
  logic b_level;
  logic button_level;

  modport source (output valid, output a_level, output b_level, output button_level,
                  input ready);
  modport sink (input valid, input a_level, input b_level, input button_level,
                output ready);
endinterface

interface red_out_if;
  logic                       valid;
  logic                       ready;
  logic [red_pkg::EventW-1:0] event_res;

  modport source (output valid, output event_res, input ready);
  modport sink (input valid, input event_res, output ready);
endinterface

// ===== rtl/red_cfg.sv =====
// APB register block of the decoder: button_present, timeout_enable, timeout_limit.
// Depends on red_pkg for the register map and the cfg_t bundle.
module red_cfg
  import red_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Write the addressed register; unmapped addresses drop the word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.button_present <= 1'b0;
      cfg_q.timeout_enable <= 1'b0;
      cfg_q.timeout_limit  <= LimitDefault;
    end else if (wr_en) begin
      case (idx)
        REG_BUTTON_PRESENT: cfg_q.button_present <= pwdata[0];
        REG_TIMEOUT_ENABLE: cfg_q.timeout_enable <= pwdata[0];
        REG_TIMEOUT_LIMIT:  cfg_q.timeout_limit  <= pwdata[LimitW-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    prdata = '0;
    case (idx)
      REG_BUTTON_PRESENT: prdata = DataW'(cfg_q.button_present);
      REG_TIMEOUT_ENABLE: prdata = DataW'(cfg_q.timeout_enable);
      REG_TIMEOUT_LIMIT:  prdata = DataW'(cfg_q.timeout_limit);
      default:            prdata = '0;
    endcase
  end

endmodule

// ===== rtl/red_core.sv =====
// Decoder core: input sample register, phase/elapsed update, event result register.
// Depends on red_pkg and the red_in_if / red_out_if interfaces.
module red_core
  import red_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  red_in_if.sink    in_ch,
  red_out_if.source out_ch
);

  // Input stage
  logic s1_valid_q;
  logic a_q, b_q, btn_q;
  // Decoder state
  phase_e              phase_q, phase_d;
  logic [ElapsedW-1:0] elapsed_q, elapsed_d, elapsed_inc;
  // Result stage
  logic   out_valid_q;
  event_e event_q;

  logic   advance;
  logic   ev_fire;
  event_e ev_code;
  logic   timed_out;

  assign advance      = s1_valid_q & (~out_valid_q | out_ch.ready);
  assign in_ch.ready  = ~s1_valid_q | advance;
  assign out_ch.valid = out_valid_q;
  assign out_ch.event_res = event_q;

  // Capture the sample word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      a_q   <= in_ch.a_level;
      b_q   <= in_ch.b_level;
      btn_q <= in_ch.button_level;
    end
  end

  // Saturating sample count, including the current sample
  assign elapsed_inc = (elapsed_q == ElapsedMax) ? elapsed_q : elapsed_q + 1'b1;
  assign timed_out   = cfg_i.timeout_enable & (elapsed_inc > {1'b0, cfg_i.timeout_limit});

  // Event decision
  always_comb begin
    ev_fire = 1'b0;
    ev_code = EV_LEFT;
    case (phase_q)
      PH_REST: begin
        if (!(cfg_i.button_present && !btn_q) && timed_out) begin
          ev_fire = 1'b1;
          ev_code = EV_TIMEOUT;
        end
      end
      PH_BUTTON: begin
        if (btn_q) begin
          ev_fire = 1'b1;
          ev_code = EV_BUTTON;
        end
      end
      PH_LEFT: begin
        if (!a_q && !b_q) begin
          ev_fire = 1'b1;
          ev_code = EV_LEFT;
        end
      end
      PH_RIGHT: begin
        if (!a_q && !b_q) begin
          ev_fire = 1'b1;
          ev_code = EV_RIGHT;
        end
      end
      default: ev_fire = 1'b0;
    endcase
  end

  // Next phase and count
  always_comb begin
    phase_d   = phase_q;
    elapsed_d = elapsed_inc;
    case (phase_q)
      PH_REST: begin
        if (cfg_i.button_present && !btn_q) begin
          phase_d = PH_BUTTON;
        end else if (timed_out) begin
          phase_d = PH_WAIT_HIGH;
        end else if (a_q && !b_q) begin
          phase_d = PH_LEFT;
        end else if (!a_q && b_q) begin
          phase_d = PH_RIGHT;
        end else if (!a_q && !b_q) begin
          phase_d = PH_WAIT_HIGH;
        end
      end
      PH_BUTTON: begin
        if (btn_q) phase_d = PH_WAIT_HIGH;
      end
      PH_LEFT: begin
        if (!(a_q && !b_q)) phase_d = PH_WAIT_HIGH;
      end
      PH_RIGHT: begin
        if (!(!a_q && b_q)) phase_d = PH_WAIT_HIGH;
      end
      default: phase_d = (a_q && b_q) ? PH_REST : PH_WAIT_HIGH;
    endcase
    if (ev_fire) begin
      elapsed_d = '0;
    end
  end

  // Advance state on each processed sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_WAIT_HIGH;
      elapsed_q <= '0;
    end else if (advance) begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= ev_fire;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && ev_fire) begin
      event_q <= ev_code;
    end
  end

`ifndef SYNTHESIS
  a_event_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && ev_fire |=> phase_q == PH_WAIT_HIGH && elapsed_q == '0)
    else $error("event did not return to waiting with cleared count");

  a_rest_only_timeout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && ev_fire && phase_q == PH_REST |-> ev_code == EV_TIMEOUT)
    else $error("non-timeout event from rest");

  a_phase_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(phase_q) && $stable(elapsed_q))
    else $error("state moved without a processed sample");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ch.ready |-> !advance)
    else $error("pending result would be overwritten");
`endif

endmodule

// ===== rtl/rotary_encoder_event_decoder.sv =====
// Top level of the rotary encoder event decoder: register block plus decoder core.
// Depends on red_pkg, red_if, red_cfg and red_core.
//
//   channel   dir   handshake              word
//   in_ch     in    valid/ready            a_level, b_level, button_level
//   out_ch    out   valid/ready            event_res (0 left, 1 right, 2 button, 3 timeout)
//   apb       in    psel/penable, pready   button_present, timeout_enable, timeout_limit
//
// One sample word is taken every cycle unless out_ch stalls; an event's result word is
// offered after the input register, one phase/count update, then the result register.
// Reset clears phase, count and the registers (timeout_limit returns to 1000).
// A result word left waiting on out_ch holds the sample in the input register, so in_ch
// stalls until that word is taken, whether or not the held sample produces an event.
module rotary_encoder_event_decoder
  import red_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  red_in_if.sink           in_ch,
  red_out_if.source        out_ch
);

  cfg_t cfg;

  red_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  red_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
